// ===== design/ipms_pkg.sv =====
`default_nettype none

package ipms_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_ENCODER_MODE      = 3'd0;
	localparam logic [2:0] REG_TARGET_SPEED      = 3'd1;
	localparam logic [2:0] REG_DRIVE_LIMIT       = 3'd2;
	localparam logic [2:0] REG_GAIN_P            = 3'd3;
	localparam logic [2:0] REG_GAIN_I            = 3'd4;
	localparam logic [2:0] REG_GAIN_D            = 3'd5;
	localparam logic [2:0] REG_TIMED_STOP_ENABLE = 3'd6;

	// Encoder latch modes
	localparam logic [1:0] MODE_FIRST  = 2'd0;
	localparam logic [1:0] MODE_SECOND = 2'd1;
	localparam logic [1:0] MODE_BOTH   = 2'd2;

	localparam logic [10:0] STOP_TICKS    = 11'd1000;
	localparam logic [15:0] INITIAL_DRIVE = 16'd0;

	// Configuration register reset values
	localparam logic [1:0]  RST_ENCODER_MODE = MODE_BOTH;
	localparam logic [15:0] RST_TARGET_SPEED = 16'd0;
	localparam logic [15:0] RST_DRIVE_LIMIT  = 16'd10000;
	localparam logic [11:0] RST_GAIN_P       = 12'd160;
	localparam logic [11:0] RST_GAIN_I       = 12'd112;
	localparam logic [11:0] RST_GAIN_D       = 12'd16;

	typedef struct packed {
		logic [1:0]  encoder_mode;
		logic [15:0] target_speed;
		logic [15:0] drive_limit;
		logic [11:0] gain_p;
		logic [11:0] gain_i;
		logic [11:0] gain_d;
		logic        timed_stop_enable;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] first_speed;
		logic signed [16:0] second_speed;
		logic [15:0]        drive_duty;
		logic               stopped;
	} result_t;

endpackage

`default_nettype wire

// ===== design/ipms_core.sv =====
`default_nettype none

module ipms_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic signed [15:0] first_count,
	input  wire logic signed [15:0] second_count,
	input  wire ipms_pkg::cfg_t     cfg,
	output ipms_pkg::result_t       result
);

	logic signed [17:0] error_last_q;
	logic signed [17:0] error_before_last_q;
	logic [15:0]        drive_q;
	logic signed [15:0] held_first_q;
	logic signed [16:0] held_second_q;
	logic [10:0]        ticks_q;

	logic signed [15:0] first_nx;
	logic signed [16:0] second_nx;
	logic [10:0]        ticks_nx;
	logic               stopped_nx;
	logic signed [16:0] speed_abs;
	logic signed [17:0] err;
	logic signed [18:0] diff_p;
	logic signed [19:0] diff_d;
	logic signed [31:0] gp_ext, gi_ext, gd_ext;
	logic signed [31:0] prod_p, prod_i, prod_d;
	logic signed [33:0] gain_sum;
	logic signed [33:0] drive_sum;
	logic [29:0]        drive_quot;
	logic [15:0]        drive_nx;

	// Latch counts according to the encoder mode; an unused mode holds both
	always_comb begin
		first_nx  = held_first_q;
		second_nx = held_second_q;
		case (cfg.encoder_mode)
			ipms_pkg::MODE_FIRST: begin
				first_nx = first_count;
			end
			ipms_pkg::MODE_SECOND: begin
				second_nx = 17'(second_count);
			end
			ipms_pkg::MODE_BOTH: begin
				first_nx  = first_count;
				second_nx = 17'(second_count);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ticks_nx = ticks_q;
		if (cfg.timed_stop_enable && ticks_q != ipms_pkg::STOP_TICKS)
			ticks_nx = ticks_q + 11'd1;
	end

	assign stopped_nx = (ticks_nx == ipms_pkg::STOP_TICKS);

	assign speed_abs = second_nx[16] ? -second_nx : second_nx;
	assign err       = $signed({2'b00, cfg.target_speed}) - 18'(speed_abs);

	assign diff_p = 19'(err) - 19'(error_last_q);
	assign diff_d = 20'(err) - (20'(error_last_q) <<< 1) + 20'(error_before_last_q);

	assign gp_ext = $signed({20'd0, cfg.gain_p});
	assign gi_ext = $signed({20'd0, cfg.gain_i});
	assign gd_ext = $signed({20'd0, cfg.gain_d});

	assign prod_p = gp_ext * 32'(diff_p);
	assign prod_i = gi_ext * 32'(err);
	assign prod_d = gd_ext * 32'(diff_d);

	assign gain_sum  = 34'(prod_p) + 34'(prod_i) + 34'(prod_d);
	assign drive_sum = $signed({14'd0, drive_q, 4'd0}) + gain_sum;
	assign drive_quot = drive_sum[33:4];

	// Truncate the Q.4 sum, then clamp to 0..drive_limit
	always_comb begin
		if (drive_sum[33] || drive_sum == 34'sd0)
			drive_nx = 16'd0;
		else if (drive_quot > {14'd0, cfg.drive_limit})
			drive_nx = cfg.drive_limit;
		else
			drive_nx = drive_quot[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_last_q        <= '0;
			error_before_last_q <= '0;
			drive_q             <= ipms_pkg::INITIAL_DRIVE;
			held_first_q        <= '0;
			held_second_q       <= '0;
			ticks_q             <= '0;
		end else if (step) begin
			held_first_q <= first_nx;
			ticks_q      <= ticks_nx;
			if (stopped_nx) begin
				held_second_q <= second_nx;
			end else begin
				held_second_q       <= speed_abs;
				error_last_q        <= err;
				error_before_last_q <= error_last_q;
				drive_q             <= drive_nx;
			end
		end
	end

	always_comb begin
		result.first_speed  = first_nx;
		result.second_speed = stopped_nx ? second_nx : speed_abs;
		result.drive_duty   = stopped_nx ? 16'd0 : drive_nx;
		result.stopped      = stopped_nx;
	end

endmodule

`default_nettype wire

// ===== design/incremental_pid_motor_speed_unit.sv =====
// Incremental PID speed loop for one motor fed by two quadrature encoders.
// Slave stream: one word per sampling tick carrying both encoder counts.
// Master stream: one word per tick with the latched counts and the forward
// duty; tuser flags that the timed stop has been reached.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while the unit is idle, which the block does not enforce. A write
// lands at the next rising edge. An accepted word is registered in the input
// register, processed by the core, and its result registered in the result
// register. Throughput is one word per cycle unless the master side stalls; the
// PID loop closes combinationally through the drive and error registers, with
// three gain multiplies feeding one adder and clamp. A master stall holds the
// result register, admits one more word, then drops s_tready until m_tready.
// Reset clears the PID state, the encoder latches and the tick counter, and
// loads the register defaults (both encoders latched, limit 10000).
`default_nettype none

module incremental_pid_motor_speed_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] first_count, [31:16] second_count
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // [15:0] first_speed, [32:16] second_speed,
	                                    // [48:33] drive_duty, rest zero
	output logic [0:0]       m_tuser,   // [0] stopped
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	ipms_pkg::cfg_t    cfg_q;
	ipms_pkg::result_t result;
	ipms_pkg::result_t out_s2;

	logic               valid_s1;
	logic signed [15:0] first_s1;
	logic signed [15:0] second_s1;
	logic               out_valid_s2;
	logic               advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoder_mode      <= ipms_pkg::RST_ENCODER_MODE;
			cfg_q.target_speed      <= ipms_pkg::RST_TARGET_SPEED;
			cfg_q.drive_limit       <= ipms_pkg::RST_DRIVE_LIMIT;
			cfg_q.gain_p            <= ipms_pkg::RST_GAIN_P;
			cfg_q.gain_i            <= ipms_pkg::RST_GAIN_I;
			cfg_q.gain_d            <= ipms_pkg::RST_GAIN_D;
			cfg_q.timed_stop_enable <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ipms_pkg::REG_ENCODER_MODE:      cfg_q.encoder_mode      <= cfg_wdata[1:0];
				ipms_pkg::REG_TARGET_SPEED:      cfg_q.target_speed      <= cfg_wdata;
				ipms_pkg::REG_DRIVE_LIMIT:       cfg_q.drive_limit       <= cfg_wdata;
				ipms_pkg::REG_GAIN_P:            cfg_q.gain_p            <= cfg_wdata[11:0];
				ipms_pkg::REG_GAIN_I:            cfg_q.gain_i            <= cfg_wdata[11:0];
				ipms_pkg::REG_GAIN_D:            cfg_q.gain_d            <= cfg_wdata[11:0];
				ipms_pkg::REG_TIMED_STOP_ENABLE: cfg_q.timed_stop_enable <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Process the held word whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			first_s1  <= $signed(s_tdata[15:0]);
			second_s1 <= $signed(s_tdata[31:16]);
		end
	end

	ipms_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.first_count  (first_s1),
		.second_count (second_s1),
		.cfg          (cfg_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_s2 <= result;
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {7'd0, out_s2.drive_duty, out_s2.second_speed, out_s2.first_speed};
	assign m_tuser  = out_s2.stopped;

endmodule

`default_nettype wire
